@@ rtl/utf8d_pkg.sv @@
`default_nettype none

package utf8d_pkg;

  localparam int unsigned MaxSeqBytes = 4;
  localparam int unsigned CntW        = $clog2(MaxSeqBytes + 1);
  localparam int unsigned CpW         = 21;
  localparam int unsigned LenW        = 3;

  typedef logic [MaxSeqBytes-1:0][7:0] pend_arr_t;

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } seq_state_e;

  // one decoded result
  typedef struct packed {
    logic [CpW-1:0]  cp;
    logic [LenW-1:0] len;
    logic            raw;
  } res_t;

  // decision of the decode unit for the current pending bytes
  typedef struct packed {
    logic emit;
    res_t res;
  } dec_t;

  // expected sequence length for a lead byte, 0 if it cannot start one
  function automatic logic [LenW-1:0] lead_len(input logic [7:0] b);
    logic [LenW-1:0] n;
    if (b < 8'h80)      n = LenW'(1);
    else if (b < 8'hC2) n = '0;
    else if (b < 8'hE0) n = LenW'(2);
    else if (b < 8'hF0) n = LenW'(3);
    else if (b < 8'hF5) n = LenW'(4);
    else                n = '0;
    return n;
  endfunction

endpackage

`default_nettype wire

@@ rtl/utf8d_pend.sv @@
`default_nettype none

// pending byte store, oldest byte at entry 0
module utf8d_pend (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        push_i,
  input  wire [7:0]                  push_byte_i,
  input  wire                        drop_i,
  input  wire [utf8d_pkg::LenW-1:0]  drop_len_i,
  output utf8d_pkg::pend_arr_t       bytes_o,
  output logic [utf8d_pkg::CntW-1:0] count_o
);

  utf8d_pkg::pend_arr_t        bytes_q, bytes_d;
  logic [utf8d_pkg::CntW-1:0]  count_q, count_d;
  logic [utf8d_pkg::CntW-1:0]  wr_pos;
  logic [2:0]                  src_idx [utf8d_pkg::MaxSeqBytes];

  // a full store overwrites its newest entry
  assign wr_pos = (count_q >= utf8d_pkg::CntW'(utf8d_pkg::MaxSeqBytes)) ?
                  utf8d_pkg::CntW'(utf8d_pkg::MaxSeqBytes - 1) : count_q;

  always_comb begin
    bytes_d = bytes_q;
    count_d = count_q;
    for (int i = 0; i < utf8d_pkg::MaxSeqBytes; i++) begin
      src_idx[i] = 3'(i) + drop_len_i;
    end
    if (push_i) begin
      bytes_d[wr_pos[1:0]] = push_byte_i;
      count_d              = wr_pos + utf8d_pkg::CntW'(1);
    end else if (drop_i) begin
      for (int i = 0; i < utf8d_pkg::MaxSeqBytes; i++) begin
        if (src_idx[i] < 3'(utf8d_pkg::MaxSeqBytes)) begin
          bytes_d[i] = bytes_q[src_idx[i][1:0]];
        end
      end
      if (utf8d_pkg::CntW'(drop_len_i) >= count_q) count_d = '0;
      else count_d = count_q - utf8d_pkg::CntW'(drop_len_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

  assign bytes_o = bytes_q;
  assign count_o = count_q;

endmodule

`default_nettype wire

@@ rtl/utf8d_decode.sv @@
`default_nettype none

// one decision on the head of the pending store
module utf8d_decode (
  input  utf8d_pkg::pend_arr_t       bytes_i,
  input  wire [utf8d_pkg::CntW-1:0]  count_i,
  input  wire                        eos_i,
  output utf8d_pkg::dec_t            dec_o
);

  logic [7:0]                 lead;
  logic [utf8d_pkg::LenW-1:0] need;
  logic [utf8d_pkg::CntW-1:0] have;
  logic                       bad;
  logic                       range_bad;
  logic                       short;
  logic [utf8d_pkg::CpW-1:0]  cp;

  assign lead  = bytes_i[0];
  assign need  = utf8d_pkg::lead_len(lead);
  assign short = count_i < utf8d_pkg::CntW'(need);
  assign have  = short ? count_i : utf8d_pkg::CntW'(need);

  always_comb begin
    cp        = '0;
    bad       = (need == '0);
    range_bad = 1'b0;
    // continuation bytes among those present
    for (int i = 1; i < utf8d_pkg::MaxSeqBytes; i++) begin
      if (utf8d_pkg::CntW'(i) < have && bytes_i[i][7:6] != 2'b10) bad = 1'b1;
    end
    // overlong, surrogate and range checks only count on a complete sequence
    case (need)
      utf8d_pkg::LenW'(1): cp = utf8d_pkg::CpW'(lead);
      utf8d_pkg::LenW'(2): begin
        cp = {10'b0, lead[4:0], bytes_i[1][5:0]};
        if (cp < 21'h80) range_bad = 1'b1;
      end
      utf8d_pkg::LenW'(3): begin
        cp = {5'b0, lead[3:0], bytes_i[1][5:0], bytes_i[2][5:0]};
        if (cp < 21'h800 || (cp >= 21'hD800 && cp <= 21'hDFFF)) range_bad = 1'b1;
      end
      utf8d_pkg::LenW'(4): begin
        cp = {lead[2:0], bytes_i[1][5:0], bytes_i[2][5:0], bytes_i[3][5:0]};
        if (cp < 21'h10000 || cp > 21'h10FFFF) range_bad = 1'b1;
      end
      default: cp = '0;
    endcase
  end

  always_comb begin
    dec_o.emit    = 1'b1;
    dec_o.res.cp  = cp;
    dec_o.res.len = need;
    dec_o.res.raw = 1'b0;
    if (count_i == '0) begin
      dec_o.emit = 1'b0;
    end else if (!(need == '0) && short && !bad && !eos_i) begin
      // valid prefix still waiting for bytes
      dec_o.emit = 1'b0;
    end else if (bad || short || range_bad) begin
      dec_o.res.cp  = utf8d_pkg::CpW'(lead);
      dec_o.res.len = utf8d_pkg::LenW'(1);
      dec_o.res.raw = 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/utf8_decoder_raw_fallback_core.sv @@
`default_nettype none

// utf-8 decoder with raw-byte fallback
//
// slave stream: one raw byte per transfer in s_axis_tdata, s_axis_tlast marks
// the last byte of the buffer. master stream: one code point per transfer,
// m_axis_tdata = {seq_length, code_point}, m_axis_tuser = raw fallback flag,
// m_axis_tlast marks the final result caused by one input byte. a byte that
// only extends a pending prefix causes no transfer at all.
//
// throughput: a byte causes 0 to 4 results; the shared decode unit makes one
// decision per cycle over the pending store unless the staged result is held,
// and the block takes no byte while it iterates. the first result of a byte is
// staged by the decision after its transfer and reaches the output register
// with the next decision. each result waits in a staging register until the
// next decision tells whether it is the last one of its byte.
// a stalled receiver holds the output register and the staging register; the
// sequencer waits until the output register frees up.
// reset empties the pending store and drops any result not yet transferred.
module utf8_decoder_raw_fallback_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire         s_axis_tlast,   // end_of_stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] seq_length
  output logic        m_axis_tuser,   // raw_fallback
  output logic        m_axis_tlast    // last_result
);

  utf8d_pkg::seq_state_e       state_q, state_d;
  logic                        eos_q, eos_d;
  logic                        stage_v_q, stage_v_d;
  utf8d_pkg::res_t             stage_q, stage_d;
  logic                        m_valid_q, m_valid_d;
  utf8d_pkg::res_t             m_data_q, m_data_d;
  logic                        m_last_q, m_last_d;

  utf8d_pkg::pend_arr_t        pend_bytes;
  logic [utf8d_pkg::CntW-1:0]  pend_count;
  utf8d_pkg::dec_t             dec;

  logic                        push;
  logic                        drop;
  logic                        out_free;
  logic                        advance;

  // pending store and the shared decode unit
  utf8d_pend u_pend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_byte_i (s_axis_tdata),
    .drop_i      (drop),
    .drop_len_i  (dec.res.len),
    .bytes_o     (pend_bytes),
    .count_o     (pend_count)
  );

  utf8d_decode u_decode (
    .bytes_i (pend_bytes),
    .count_i (pend_count),
    .eos_i   (eos_q),
    .dec_o   (dec)
  );

  assign s_axis_tready = (state_q == utf8d_pkg::ST_IDLE);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  // a step may go ahead once the staged result has somewhere to go
  assign advance       = (state_q == utf8d_pkg::ST_EVAL) && (!stage_v_q || out_free);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      utf8d_pkg::ST_IDLE: if (push) state_d = utf8d_pkg::ST_EVAL;
      utf8d_pkg::ST_EVAL: if (advance && !dec.emit) state_d = utf8d_pkg::ST_IDLE;
      default:            state_d = utf8d_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    eos_d     = push ? s_axis_tlast : eos_q;
    stage_v_d = stage_v_q;
    stage_d   = stage_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;
    drop      = 1'b0;
    if (advance) begin
      if (stage_v_q) begin
        // staged result leaves; last when no further result follows
        m_valid_d = 1'b1;
        m_data_d  = stage_q;
        m_last_d  = !dec.emit;
      end
      if (dec.emit) begin
        stage_v_d = 1'b1;
        stage_d   = dec.res;
        drop      = 1'b1;
      end else begin
        stage_v_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= utf8d_pkg::ST_IDLE;
      eos_q     <= 1'b0;
      stage_v_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      eos_q     <= eos_d;
      stage_v_q <= stage_v_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q  <= stage_d;
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_data_q.len, m_data_q.cp};
  assign m_axis_tuser  = m_data_q.raw;
  assign m_axis_tlast  = m_last_q;

  // no result is left staged when a new byte comes in
  a_stage_empty_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !stage_v_q)
    else $error("staged result still present while accepting a byte");

  // end of buffer leaves the pending store empty
  a_eos_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == utf8d_pkg::ST_IDLE && eos_q) |-> (pend_count == '0))
    else $error("pending bytes left after end of buffer");

  // fallback results always consume exactly one byte
  a_raw_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_data_q.raw) |-> (m_data_q.len == utf8d_pkg::LenW'(1)))
    else $error("raw fallback with length other than one");

  // pending store never holds more than a full sequence
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_count <= utf8d_pkg::CntW'(utf8d_pkg::MaxSeqBytes))
    else $error("pending count out of range");

endmodule

`default_nettype wire

@@ tb/sv/utf8_decoder_raw_fallback_core_tb.sv @@
`timescale 1ns / 1ps

module utf8_decoder_raw_fallback_core_tb;

  localparam int unsigned RandBytes     = 470;
  localparam int unsigned MaxWait       = 11;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned MaxPrinted    = 100;

  // one decoded code point as it leaves the block
  typedef struct packed {
    logic [utf8d_pkg::CpW-1:0]  cp;
    logic [utf8d_pkg::LenW-1:0] len;
    logic                       raw;
    logic                       last;
  } cp_res_t;

  // one byte of the buffer; rows with fixed_res carry their own expectation
  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    logic       fixed_res;
    cp_res_t    want;
  } byte_row_t;

  // directed rows: fallback and edge cases first, then sequences that need the decoder
  localparam int unsigned DirRows = 25;
  localparam byte_row_t DirTab [DirRows] = '{
    '{8'h00, 1'b0, 1'b1, '{21'h000000, 3'd1, 1'b0, 1'b1}},  // nul decodes normally
    '{8'h7F, 1'b1, 1'b1, '{21'h00007F, 3'd1, 1'b0, 1'b1}},  // top of ascii, end mark
    '{8'h80, 1'b0, 1'b1, '{21'h000080, 3'd1, 1'b1, 1'b1}},  // stray continuation
    '{8'hC1, 1'b0, 1'b1, '{21'h0000C1, 3'd1, 1'b1, 1'b1}},  // overlong-only lead
    '{8'hF5, 1'b0, 1'b1, '{21'h0000F5, 3'd1, 1'b1, 1'b1}},  // lead beyond range
    '{8'hC2, 1'b0, 1'b0, '0},                               // smallest two-byte form
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'hF4, 1'b0, 1'b0, '0},                               // largest code point
    '{8'h8F, 1'b0, 1'b0, '0},
    '{8'hBF, 1'b0, 1'b0, '0},
    '{8'hBF, 1'b0, 1'b0, '0},
    '{8'hE0, 1'b0, 1'b0, '0},                               // overlong three-byte form
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'hED, 1'b0, 1'b0, '0},                               // surrogate
    '{8'hA0, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'hF4, 1'b0, 1'b0, '0},                               // just above the maximum
    '{8'h90, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'hC2, 1'b0, 1'b0, '0},                               // non-continuation breaks in
    '{8'h41, 1'b0, 1'b0, '0},
    '{8'hE2, 1'b0, 1'b0, '0},                               // cut off by the end mark
    '{8'h82, 1'b1, 1'b0, '0}
  };

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // decoder state of the predictor
  logic [7:0]  held_bytes [utf8d_pkg::MaxSeqBytes];
  int unsigned held_cnt = 0;

  byte_row_t   byte_q [$];
  cp_res_t     cp_due_q [$];
  int unsigned err_cnt = 0;
  int unsigned idle_cycles = 0;

  utf8_decoder_raw_fallback_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    if (err_cnt < MaxPrinted) $display("%0t ns mismatch: %s", $time, what);
    err_cnt++;
  endtask

  // append one byte to the held bytes and decide as much as possible
  function automatic void decode_byte(input logic [7:0] b, input logic eos,
                                      output cp_res_t res [$]);
    logic [7:0]                lead;
    logic [utf8d_pkg::CpW-1:0] cp;
    logic                      bad;
    int unsigned               need;
    int unsigned               have;
    int unsigned               drop;
    int unsigned               i;
    res.delete();
    if (held_cnt >= utf8d_pkg::MaxSeqBytes) held_cnt = utf8d_pkg::MaxSeqBytes - 1;
    held_bytes[held_cnt] = b;
    held_cnt++;
    while (held_cnt > 0 && res.size() < utf8d_pkg::MaxSeqBytes) begin
      lead = held_bytes[0];
      if (lead < 8'h80)      need = 1;
      else if (lead < 8'hC2) need = 0;
      else if (lead < 8'hE0) need = 2;
      else if (lead < 8'hF0) need = 3;
      else if (lead < 8'hF5) need = 4;
      else                   need = 0;
      bad = (need == 0);
      if (!bad) begin
        have = (held_cnt < need) ? held_cnt : need;
        for (i = 1; i < have; i++)
          if (held_bytes[i][7:6] != 2'b10) bad = 1'b1;
      end
      // a valid prefix waits for more bytes unless the buffer ends here
      if (!bad && held_cnt < need) begin
        if (!eos) break;
        bad = 1'b1;
      end
      if (!bad) begin
        case (need)
          1: cp = utf8d_pkg::CpW'(lead);
          2: begin
            cp = utf8d_pkg::CpW'({lead[4:0], held_bytes[1][5:0]});
            if (cp < 21'h80) bad = 1'b1;
          end
          3: begin
            cp = utf8d_pkg::CpW'({lead[3:0], held_bytes[1][5:0], held_bytes[2][5:0]});
            if (cp < 21'h800 || (cp >= 21'hD800 && cp <= 21'hDFFF)) bad = 1'b1;
          end
          default: begin
            cp = {lead[2:0], held_bytes[1][5:0], held_bytes[2][5:0], held_bytes[3][5:0]};
            if (cp < 21'h10000 || cp > 21'h10FFFF) bad = 1'b1;
          end
        endcase
      end
      // fallback: only the lead byte goes out raw, the rest is replayed
      if (bad) begin
        cp   = utf8d_pkg::CpW'(lead);
        drop = 1;
      end else begin
        drop = need;
      end
      res.push_back('{cp, utf8d_pkg::LenW'(drop), bad, 1'b0});
      for (i = 0; i + drop < held_cnt; i++) held_bytes[i] = held_bytes[i + drop];
      held_cnt -= drop;
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
  endfunction

  // stimulus, driver and end of run
  initial begin
    cp_res_t                   found [$];
    logic [7:0]                enc [utf8d_pkg::MaxSeqBytes];
    logic [utf8d_pkg::CpW-1:0] cpv;
    logic [1:0]                hi;
    logic                      eos_bit;
    logic                      in_calm;
    int unsigned               mode;
    int unsigned               nb;
    int unsigned               pos;
    int unsigned               gap;
    int unsigned               rand_cnt;

    foreach (DirTab[k]) byte_q.push_back(DirTab[k]);

    // random part: mostly well-formed sequences, some malformed ones and noise
    rand_cnt = 0;
    while (rand_cnt < RandBytes) begin
      mode = $urandom_range(0, 15);
      if (mode >= 14) begin
        nb = $urandom_range(1, 4);
        for (int k = 0; k < nb; k++) begin
          byte_q.push_back('{8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0,
                             1'b0, '0});
        end
      end else begin
        case (mode)
          9: begin  // overlong
            nb = $urandom_range(2, 4);
            cpv = (nb == 2) ? utf8d_pkg::CpW'($urandom_range(0, 'h7F)) :
                  (nb == 3) ? utf8d_pkg::CpW'($urandom_range(0, 'h7FF)) :
                              utf8d_pkg::CpW'($urandom_range(0, 'hFFFF));
          end
          10: begin  // surrogate
            nb  = 3;
            cpv = utf8d_pkg::CpW'($urandom_range('hD800, 'hDFFF));
          end
          11: begin  // above the maximum
            nb  = 4;
            cpv = utf8d_pkg::CpW'($urandom_range('h110000, 'h1FFFFF));
          end
          default: begin
            nb = (mode >= 12) ? $urandom_range(2, 4) : $urandom_range(1, 4);
            case (nb)
              1:       cpv = utf8d_pkg::CpW'($urandom_range(0, 'h7F));
              2:       cpv = utf8d_pkg::CpW'($urandom_range('h80, 'h7FF));
              3:       cpv = utf8d_pkg::CpW'($urandom_range('h800, 'hFFFF));
              default: cpv = utf8d_pkg::CpW'($urandom_range('h10000, 'h10FFFF));
            endcase
          end
        endcase
        case (nb)
          1: enc[0] = {1'b0, cpv[6:0]};
          2: begin
            enc[0] = {3'b110, cpv[10:6]};
            enc[1] = {2'b10, cpv[5:0]};
          end
          3: begin
            enc[0] = {4'b1110, cpv[15:12]};
            enc[1] = {2'b10, cpv[11:6]};
            enc[2] = {2'b10, cpv[5:0]};
          end
          default: begin
            enc[0] = {5'b11110, cpv[20:18]};
            enc[1] = {2'b10, cpv[17:12]};
            enc[2] = {2'b10, cpv[11:6]};
            enc[3] = {2'b10, cpv[5:0]};
          end
        endcase
        if (mode == 12) begin
          // truncated: drop the tail
          nb = $urandom_range(1, nb - 1);
        end else if (mode == 13) begin
          // a non-continuation byte breaks into the sequence
          pos = $urandom_range(1, nb - 1);
          hi  = 2'($urandom_range(0, 2));
          if (hi == 2'b10) hi = 2'b11;
          enc[pos] = {hi, 6'($urandom_range(0, 63))};
        end
        for (int k = 0; k < nb; k++) begin
          eos_bit = 1'b0;
          if (k == nb - 1)
            eos_bit = (mode == 12) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) == 0);
          byte_q.push_back('{enc[k], eos_bit, 1'b0, '0});
        end
      end
      rand_cnt += nb;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    in_calm = 1'b0;
    foreach (byte_q[idx]) begin
      gap = in_calm ? 0 : $urandom_range(0, MaxWait);
      if ($urandom_range(0, 15) == 0) in_calm = !in_calm;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= byte_q[idx].data;
      s_axis_tlast  <= byte_q[idx].eos;
      do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
      // transfer taken at this edge: run the predictor on it
      decode_byte(byte_q[idx].data, byte_q[idx].eos, found);
      if (byte_q[idx].fixed_res) cp_due_q.push_back(byte_q[idx].want);
      else foreach (found[k]) cp_due_q.push_back(found[k]);
    end
    s_axis_tvalid <= 1'b0;

    while (cp_due_q.size() != 0) @(posedge clk_i);
    // leave room for any result that should not be there
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // receiver: random stalls, each transfer checked against the oldest expectation
  initial begin
    cp_res_t     got;
    cp_res_t     want;
    logic        out_calm;
    int unsigned stall;
    out_calm = 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = out_calm ? 0 : $urandom_range(0, MaxWait);
      if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      got = '{m_axis_tdata[20:0], m_axis_tdata[23:21], m_axis_tuser, m_axis_tlast};
      if (cp_due_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result cp %h len %0d raw %b last %b",
                                  got.cp, got.len, got.raw, got.last));
      end else begin
        want = cp_due_q.pop_front();
        if (got !== want)
          report_mismatch($sformatf("cp %h len %0d raw %b last %b, want cp %h len %0d raw %b last %b",
                                    got.cp, got.len, got.raw, got.last,
                                    want.cp, want.len, want.raw, want.last));
      end
    end
  end

  // watchdog: too long without any transfer on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ files.f @@
rtl/utf8d_pkg.sv
rtl/utf8d_pend.sv
rtl/utf8d_decode.sv
rtl/utf8_decoder_raw_fallback_core.sv
tb/sv/utf8_decoder_raw_fallback_core_tb.sv
